// ===== rtl/core/vector3_math_unit_core_defines.svh =====
// ----------------------------------------------------------------------------
// Vector3 math unit - assertion macros
// Shared concurrent check forms, clocked on clk, quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_MATH_UNIT_CORE_DEFINES_SVH
`define VECTOR3_MATH_UNIT_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define V3MU_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vector3 math unit check failed");

// Consequent must hold in the cycle after the antecedent.
`define V3MU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vector3 math unit check failed");

`endif

// ===== rtl/core/v3mu_pkg.sv =====
// ----------------------------------------------------------------------------
// v3mu_pkg
// Command codes and fixed field widths of the vector3 math unit.
// ----------------------------------------------------------------------------
package v3mu_pkg;

	localparam int unsigned FIELD_BITS = 32;
	localparam int unsigned CMD_BITS   = 3;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_ADD       = 3'd0,
		CMD_SUB       = 3'd1,
		CMD_SCALE     = 3'd2,
		CMD_DOT       = 3'd3,
		CMD_CROSS     = 3'd4,
		CMD_NORM      = 3'd5,
		CMD_NORMALIZE = 3'd6
	} cmd_t;

endpackage

// ===== rtl/core/v3mu_lane.sv =====
// ----------------------------------------------------------------------------
// v3mu_lane
// One component lane: two signed products and a saturating add/subtract,
// registered for the merge stage.
// ----------------------------------------------------------------------------
module v3mu_lane import v3mu_pkg::*; #(
	parameter int unsigned S = 32
) (
	input  logic                  clk,
	input  logic                  en,
	input  cmd_t                  cmd,
	input  logic signed [S-1:0]   a_i,
	input  logic signed [S-1:0]   a_j,
	input  logic signed [S-1:0]   a_k,
	input  logic signed [S-1:0]   b_i,
	input  logic signed [S-1:0]   b_j,
	input  logic signed [S-1:0]   b_k,
	input  logic signed [S-1:0]   scl,
	output logic signed [2*S-1:0] p0_s1,
	output logic signed [2*S-1:0] p1_s1,
	output logic signed [S-1:0]   lin_s1,
	output logic                  lin_sat_s1
);

	logic signed [S-1:0]   m0a;
	logic signed [S-1:0]   m0b;
	logic signed [2*S-1:0] prod0;
	logic signed [2*S-1:0] prod1;
	logic signed [S:0]     sum;
	logic signed [S-1:0]   lin;
	logic                  lin_sat;

	// pick the operands of the shared product for the command
	always_comb begin
		unique case (cmd)
			CMD_SCALE: begin
				m0a = scl;
				m0b = a_i;
			end
			CMD_DOT: begin
				m0a = b_i;
				m0b = a_i;
			end
			CMD_CROSS: begin
				m0a = b_k;
				m0b = a_j;
			end
			default: begin
				m0a = a_i;
				m0b = a_i;
			end
		endcase
	end

	assign prod0 = m0a * m0b;
	assign prod1 = a_k * b_j;

	always_comb begin
		if (cmd == CMD_SUB) begin
			sum = (S+1)'(a_i) - (S+1)'(b_i);
		end else begin
			sum = (S+1)'(a_i) + (S+1)'(b_i);
		end
		lin_sat = sum[S] != sum[S-1];
		if (!lin_sat) begin
			lin = sum[S-1:0];
		end else if (sum[S]) begin
			lin = {1'b1, {(S-1){1'b0}}};
		end else begin
			lin = {1'b0, {(S-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1      <= prod0;
			p1_s1      <= prod1;
			lin_s1     <= lin;
			lin_sat_s1 <= lin_sat;
		end
	end

endmodule

// ===== rtl/core/v3mu_isqrt.sv =====
// ----------------------------------------------------------------------------
// v3mu_isqrt
// Pipelined integer square root, one root bit per stage, RW stages.
// ----------------------------------------------------------------------------
module v3mu_isqrt import v3mu_pkg::*; #(
	parameter int unsigned RW = 32
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*RW-1:0] rad,
	output logic [RW-1:0]   root
);

	logic [RW+1:0]   rem_q [RW];
	logic [RW-1:0]   q_q   [RW];
	logic [2*RW-1:0] rad_q [RW];

	for (genvar g = 0; g < RW; g++) begin : g_stage
		logic [RW+1:0]   rem_prev;
		logic [RW-1:0]   q_prev;
		logic [2*RW-1:0] rad_prev;
		logic [RW+1:0]   rem_sh;
		logic [RW+1:0]   trial;
		logic            ge;

		if (g == 0) begin : g_first
			assign rem_prev = '0;
			assign q_prev   = '0;
			assign rad_prev = rad;
		end else begin : g_next
			assign rem_prev = rem_q[g-1];
			assign q_prev   = q_q[g-1];
			assign rad_prev = rad_q[g-1];
		end

		// bring down the next two radicand bits and try the next root bit
		assign rem_sh = {rem_prev[RW-1:0], rad_prev[2*RW-1 -: 2]};
		assign trial  = {q_prev, 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[g] <= ge ? rem_sh - trial : rem_sh;
				q_q[g]   <= {q_prev[RW-2:0], ge};
				rad_q[g] <= {rad_prev[2*RW-3:0], 2'b00};
			end
		end
	end

	assign root = q_q[RW-1];

endmodule

// ===== rtl/core/v3mu_divider.sv =====
// ----------------------------------------------------------------------------
// v3mu_divider
// Pipelined restoring divider: magnitude over norm with FB fraction bits,
// one quotient bit per stage, FB+1 stages.
// ----------------------------------------------------------------------------
module v3mu_divider import v3mu_pkg::*; #(
	parameter int unsigned DW = 32,
	parameter int unsigned FB = 16
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] mag,
	input  logic [DW-1:0] norm,
	input  logic          neg,
	output logic [FB:0]   quo,
	output logic          neg_out,
	output logic [DW-1:0] norm_out
);

	logic [DW-1:0] r_q    [FB+1];
	logic [FB:0]   q_q    [FB+1];
	logic [DW-1:0] norm_q [FB+1];
	logic          neg_q  [FB+1];

	for (genvar g = 0; g <= FB; g++) begin : g_stage
		logic [DW:0]   r_sh;
		logic [FB:0]   q_prev;
		logic [DW-1:0] norm_prev;
		logic          neg_prev;
		logic          ge;

		if (g == 0) begin : g_first
			assign r_sh      = {1'b0, mag};
			assign q_prev    = '0;
			assign norm_prev = norm;
			assign neg_prev  = neg;
		end else begin : g_next
			assign r_sh      = {r_q[g-1], 1'b0};
			assign q_prev    = q_q[g-1];
			assign norm_prev = norm_q[g-1];
			assign neg_prev  = neg_q[g-1];
		end

		assign ge = r_sh >= {1'b0, norm_prev};

		always_ff @(posedge clk) begin
			if (en) begin
				r_q[g]    <= ge ? DW'(r_sh - {1'b0, norm_prev}) : r_sh[DW-1:0];
				q_q[g]    <= {q_prev[FB-1:0], ge};
				norm_q[g] <= norm_prev;
				neg_q[g]  <= neg_prev;
			end
		end
	end

	assign quo      = q_q[FB];
	assign neg_out  = neg_q[FB];
	assign norm_out = norm_q[FB];

endmodule

// ===== rtl/core/vector3_math_unit_core.sv =====
// ----------------------------------------------------------------------------
// vector3_math_unit_core
// Three-component Q-format vector unit: add, subtract, scale, dot, cross,
// norm and normalize, fully pipelined.
//
// Input channel: in_valid/in_ready carry a command, two vectors and a scale
// factor; a transfer happens when both are high. Output channel:
// out_valid/out_ready carry result_x/y/z, result_scalar and the saturated and
// zero_length flags, one result per input.
// Throughput is one item per clock while the pipeline is not held (below);
// the depth is set by the S-stage square root followed by the F+1-stage
// divider lanes, which every item passes, where S is the smaller of
// WORD_BITS and 32 and F is FRACTION_BITS.
// When the receiver stalls, the result stays in the output register and the
// pipeline still advances as long as its last stage is empty; otherwise it
// holds and in_ready drops.
// Reset clears all valid bits and the output register's valid; nothing else
// needs clearing and the unit takes input right after reset.
// ----------------------------------------------------------------------------
`include "vector3_math_unit_core_defines.svh"

module vector3_math_unit_core import v3mu_pkg::*; #(
	parameter int unsigned WORD_BITS     = 32,
	parameter int unsigned FRACTION_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [CMD_BITS-1:0]          command,
	input  logic signed [FIELD_BITS-1:0] first_x,
	input  logic signed [FIELD_BITS-1:0] first_y,
	input  logic signed [FIELD_BITS-1:0] first_z,
	input  logic signed [FIELD_BITS-1:0] second_x,
	input  logic signed [FIELD_BITS-1:0] second_y,
	input  logic signed [FIELD_BITS-1:0] second_z,
	input  logic signed [FIELD_BITS-1:0] scale_factor,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [FIELD_BITS-1:0] result_x,
	output logic signed [FIELD_BITS-1:0] result_y,
	output logic signed [FIELD_BITS-1:0] result_z,
	output logic signed [FIELD_BITS-1:0] result_scalar,
	output logic                         saturated,
	output logic                         zero_length
);

	localparam int unsigned S = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
	localparam int unsigned F = FRACTION_BITS;
	localparam int unsigned P = 2 * S;
	localparam int unsigned W = 2 * S + 2;
	localparam int unsigned D = S + F + 1;

	typedef struct packed {
		cmd_t               cmd;
		logic [2:0][S-1:0]  v;
		logic [S-1:0]       vs;
		logic               sat;
		logic [2:0][S-1:0]  a;
	} sb_t;

	// clamp a wide signed value to S bits; the top bit returned is the flag
	function automatic logic [S:0] sat_w(input logic signed [W-1:0] x);
		if ((&x[W-1:S-1]) || !(|x[W-1:S-1])) begin
			return {1'b0, x[S-1:0]};
		end else if (x[W-1]) begin
			return {1'b1, 1'b1, {(S-1){1'b0}}};
		end else begin
			return {1'b1, 1'b0, {(S-1){1'b1}}};
		end
	endfunction

	logic                adv;
	cmd_t                cmd_in;
	logic signed [S-1:0] op_a [3];
	logic signed [S-1:0] op_b [3];
	logic signed [S-1:0] op_s;

	// stage 1
	logic                vld_s1;
	cmd_t                cmd_s1;
	logic signed [S-1:0] a_s1 [3];
	logic signed [P-1:0] p0_s1 [3];
	logic signed [P-1:0] p1_s1 [3];
	logic signed [S-1:0] lin_s1 [3];
	logic                lin_sat_s1 [3];

	// stage 2
	logic                vld_s2;
	cmd_t                cmd_s2;
	logic signed [S-1:0] a_s2 [3];
	logic signed [W-1:0] w_s2 [3];
	logic signed [W-1:0] sum_s2;
	logic signed [S-1:0] lin_s2 [3];
	logic                lin_sat_s2 [3];

	// sideband line alongside root and divider stages
	sb_t                 sb_d;
	sb_t                 sb_q [D];
	logic                vld_q [D];

	logic [S-1:0]        root_sq;
	logic [S-1:0]        div_mag [3];
	logic                div_neg [3];
	logic [F:0]          quo [3];
	logic                neg_out [3];
	logic [S-1:0]        norm_out [3];

	// final stage and output register
	logic [2:0][S-1:0]   fin_v;
	logic [S-1:0]        fin_s;
	logic                fin_sat;
	logic                fin_zero;
	logic                out_valid_q;
	logic [2:0][S-1:0]   out_v_q;
	logic [S-1:0]        out_s_q;
	logic                sat_q;
	logic                zero_length_q;

	// advance unless a waiting result would be overwritten
	assign adv      = out_ready || !out_valid_q || !vld_q[D-1];
	assign in_ready = adv;

	assign cmd_in  = cmd_t'(command);
	assign op_a[0] = first_x[S-1:0];
	assign op_a[1] = first_y[S-1:0];
	assign op_a[2] = first_z[S-1:0];
	assign op_b[0] = second_x[S-1:0];
	assign op_b[1] = second_y[S-1:0];
	assign op_b[2] = second_z[S-1:0];
	assign op_s    = scale_factor[S-1:0];

	for (genvar g = 0; g < 3; g++) begin : g_lane
		v3mu_lane #(.S(S)) u_lane (
			.clk        (clk),
			.en         (adv),
			.cmd        (cmd_in),
			.a_i        (op_a[g]),
			.a_j        (op_a[(g+1)%3]),
			.a_k        (op_a[(g+2)%3]),
			.b_i        (op_b[g]),
			.b_j        (op_b[(g+1)%3]),
			.b_k        (op_b[(g+2)%3]),
			.scl        (op_s),
			.p0_s1      (p0_s1[g]),
			.p1_s1      (p1_s1[g]),
			.lin_s1     (lin_s1[g]),
			.lin_sat_s1 (lin_sat_s1[g])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= cmd_in;
			for (int g = 0; g < 3; g++) begin
				a_s1[g] <= op_a[g];
			end
		end
	end

	// merge lanes: cross differences and the three-term sum
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2 <= cmd_s1;
			sum_s2 <= W'(p0_s1[0]) + W'(p0_s1[1]) + W'(p0_s1[2]);
			for (int g = 0; g < 3; g++) begin
				a_s2[g]       <= a_s1[g];
				lin_s2[g]     <= lin_s1[g];
				lin_sat_s2[g] <= lin_sat_s1[g];
				if (cmd_s1 == CMD_CROSS) begin
					w_s2[g] <= W'(p0_s1[g]) - W'(p1_s1[g]);
				end else begin
					w_s2[g] <= W'(p0_s1[g]);
				end
			end
		end
	end

	// shift out the fraction of the products and clamp everything but the root paths
	always_comb begin
		logic [S:0] tmp;
		tmp      = '0;
		sb_d     = '0;
		sb_d.cmd = cmd_s2;
		for (int g = 0; g < 3; g++) begin
			sb_d.a[g] = a_s2[g];
		end
		unique case (cmd_s2)
			CMD_ADD, CMD_SUB: begin
				for (int g = 0; g < 3; g++) begin
					sb_d.v[g] = lin_s2[g];
					sb_d.sat  = sb_d.sat | lin_sat_s2[g];
				end
			end
			CMD_SCALE, CMD_CROSS: begin
				for (int g = 0; g < 3; g++) begin
					tmp       = sat_w(w_s2[g] >>> F);
					sb_d.v[g] = tmp[S-1:0];
					sb_d.sat  = sb_d.sat | tmp[S];
				end
			end
			CMD_DOT: begin
				tmp      = sat_w(sum_s2 >>> F);
				sb_d.vs  = tmp[S-1:0];
				sb_d.sat = tmp[S];
			end
			default: begin
			end
		endcase
	end

	v3mu_isqrt #(.RW(S)) u_isqrt (
		.clk  (clk),
		.en   (adv),
		.rad  (sum_s2[P-1:0]),
		.root (root_sq)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_q[0] <= sb_d;
			for (int k = 1; k < D; k++) begin
				sb_q[k] <= sb_q[k-1];
			end
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_div
		assign div_neg[g] = sb_q[S-1].a[g][S-1];
		assign div_mag[g] = div_neg[g] ? S'(-sb_q[S-1].a[g]) : sb_q[S-1].a[g];

		v3mu_divider #(.DW(S), .FB(F)) u_div (
			.clk      (clk),
			.en       (adv),
			.mag      (div_mag[g]),
			.norm     (root_sq),
			.neg      (div_neg[g]),
			.quo      (quo[g]),
			.neg_out  (neg_out[g]),
			.norm_out (norm_out[g])
		);
	end

	// root-based commands finish here
	always_comb begin
		logic signed [F+1:0] qs;
		logic [S:0]          tmp;
		qs       = '0;
		tmp      = '0;
		fin_v    = sb_q[D-1].v;
		fin_s    = sb_q[D-1].vs;
		fin_sat  = sb_q[D-1].sat;
		fin_zero = 1'b0;
		unique case (sb_q[D-1].cmd)
			CMD_NORM: begin
				fin_sat = norm_out[0][S-1];
				fin_s   = norm_out[0][S-1] ? {1'b0, {(S-1){1'b1}}} : norm_out[0];
			end
			CMD_NORMALIZE: begin
				if (norm_out[0] == '0) begin
					fin_zero = 1'b1;
				end else begin
					for (int g = 0; g < 3; g++) begin
						qs       = neg_out[g] ? -signed'({1'b0, quo[g]})
							: signed'({1'b0, quo[g]});
						tmp      = sat_w(W'(qs));
						fin_v[g] = tmp[S-1:0];
						fin_sat  = fin_sat | tmp[S];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			for (int k = 0; k < D; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s1   <= in_valid;
			vld_s2   <= vld_s1;
			vld_q[0] <= vld_s2;
			for (int k = 1; k < D; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && vld_q[D-1]) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_q[D-1]) begin
			out_v_q       <= fin_v;
			out_s_q       <= fin_s;
			sat_q         <= fin_sat;
			zero_length_q <= fin_zero;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_x      = FIELD_BITS'(signed'(out_v_q[0]));
	assign result_y      = FIELD_BITS'(signed'(out_v_q[1]));
	assign result_z      = FIELD_BITS'(signed'(out_v_q[2]));
	assign result_scalar = FIELD_BITS'(signed'(out_s_q));
	assign saturated     = sat_q;
	assign zero_length   = zero_length_q;

	`V3MU_ASSERT_SAME(a_zero_clean, out_valid_q && zero_length_q, (out_v_q == '0) && (out_s_q == '0) && !sat_q)
	`V3MU_ASSERT_NEXT(a_load_shows, adv && vld_q[D-1], out_valid_q)
	`V3MU_ASSERT_SAME(a_hold_blocks, out_valid_q && !out_ready && vld_q[D-1], !in_ready)

endmodule
